// ----- hdl/tle_pkg.sv -----
// Shared types, codes and constants of the terminal line editor.
// Used by tle_seq and terminal_line_editor; depends on nothing else.
`default_nettype none

package tle_pkg;

	// Size of the line store and the widths that follow from it.
	localparam int BUFFER_BYTES = 32;
	localparam int CAP_CHARS    = BUFFER_BYTES - 1;
	localparam int IDX_W        = $clog2(BUFFER_BYTES);
	localparam int COUNT_W      = 5;
	localparam int BYTE_W       = 8;
	localparam int KIND_W       = 3;

	// Result kinds.
	localparam logic [KIND_W-1:0] K_ECHO = 3'd0;
	localparam logic [KIND_W-1:0] K_CHAR = 3'd1;
	localparam logic [KIND_W-1:0] K_END  = 3'd2;
	localparam logic [KIND_W-1:0] K_UP   = 3'd3;
	localparam logic [KIND_W-1:0] K_DOWN = 3'd4;

	// Terminal byte codes.
	localparam logic [BYTE_W-1:0] C_ESC     = 8'h1B;
	localparam logic [BYTE_W-1:0] C_BRACKET = 8'h5B;
	localparam logic [BYTE_W-1:0] C_UP      = 8'h41;
	localparam logic [BYTE_W-1:0] C_DOWN    = 8'h42;
	localparam logic [BYTE_W-1:0] C_DEL     = 8'h7F;
	localparam logic [BYTE_W-1:0] C_BS      = 8'h08;
	localparam logic [BYTE_W-1:0] C_CR      = 8'h0D;
	localparam logic [BYTE_W-1:0] C_LF      = 8'h0A;

	// Configuration register indexes.
	localparam logic [1:0] REG_MAX_CHARS = 2'd0;

	// One result as it leaves the block.
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [BYTE_W-1:0]  out_byte;
		logic [COUNT_W-1:0] line_length;
		logic               last;
	} tle_result_t;

	// Status reported by the sequencer to the top level.
	typedef struct packed {
		logic               idle;
		logic [COUNT_W-1:0] count;
	} tle_status_t;

endpackage

`default_nettype wire

// ----- hdl/tle_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; has no package dependency.
`default_nettype none

module tle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/tle_seq.sv -----
// Line editing sequencer: decodes each input byte, drives the line store
// and holds the output result register. Depends on tle_pkg.
`default_nettype none

module tle_seq (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [tle_pkg::COUNT_W-1:0]      max_chars,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [tle_pkg::BYTE_W-1:0]       in_byte,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output tle_pkg::tle_result_t                  result,
	output logic                                  ram_we,
	output logic      [tle_pkg::IDX_W-1:0]        ram_waddr,
	output logic      [tle_pkg::BYTE_W-1:0]       ram_wdata,
	output logic                                  ram_re,
	output logic      [tle_pkg::IDX_W-1:0]        ram_raddr,
	input  wire logic [tle_pkg::BYTE_W-1:0]       ram_rdata,
	output tle_pkg::tle_status_t                  status
);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ONE   = 3'd1;
	localparam logic [2:0] ST_CR    = 3'd2;
	localparam logic [2:0] ST_LF    = 3'd3;
	localparam logic [2:0] ST_RADDR = 3'd4;
	localparam logic [2:0] ST_RDATA = 3'd5;
	localparam logic [2:0] ST_END   = 3'd6;

	// Escape phases.
	localparam logic [1:0] ESC_NONE   = 2'd0;
	localparam logic [1:0] ESC_SECOND = 2'd1;
	localparam logic [1:0] ESC_THIRD  = 2'd2;

	logic [2:0]                    state_q, state_d;
	logic [1:0]                    phase_q, phase_d;
	logic                          bracket_q, bracket_d;
	logic                          first_cr_q, first_cr_d;
	logic [tle_pkg::COUNT_W-1:0]   count_q, count_d;
	logic [tle_pkg::COUNT_W-1:0]   idx_q, idx_d;
	logic [tle_pkg::KIND_W-1:0]    pend_kind_q, pend_kind_d;
	logic [tle_pkg::BYTE_W-1:0]    pend_byte_q, pend_byte_d;
	logic                          out_valid_q;
	tle_pkg::tle_result_t          out_q;
	tle_pkg::tle_result_t          res;
	logic                          push;
	logic                          free;
	logic [tle_pkg::COUNT_W-1:0]   limit;

	// The limit in use is the register capped at the store size less one.
	always_comb begin
		if (int'(max_chars) > tle_pkg::CAP_CHARS) begin
			limit = tle_pkg::COUNT_W'(tle_pkg::CAP_CHARS);
		end else begin
			limit = max_chars;
		end
	end

	assign free     = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	// Next-state logic: byte decode in idle, then at most one result per step.
	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		bracket_d   = bracket_q;
		first_cr_d  = first_cr_q;
		count_d     = count_q;
		idx_d       = idx_q;
		pend_kind_d = pend_kind_q;
		pend_byte_d = pend_byte_q;
		push        = 1'b0;
		res         = '0;
		ram_we      = 1'b0;
		ram_waddr   = tle_pkg::IDX_W'(count_q);
		ram_wdata   = in_byte;
		ram_re      = 1'b0;
		ram_raddr   = tle_pkg::IDX_W'(idx_q);

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					idx_d = '0;
					if (phase_q == ESC_SECOND) begin
						// Second byte of an escape: remember what it was.
						bracket_d  = (in_byte == tle_pkg::C_BRACKET);
						first_cr_d = (in_byte == tle_pkg::C_CR);
						phase_d    = ESC_THIRD;
					end else if (phase_q == ESC_THIRD) begin
						// Third byte ends the escape.
						phase_d = ESC_NONE;
						if (bracket_q && (in_byte == tle_pkg::C_UP ||
								in_byte == tle_pkg::C_DOWN)) begin
							count_d     = '0;
							pend_kind_d = (in_byte == tle_pkg::C_UP) ?
								tle_pkg::K_UP : tle_pkg::K_DOWN;
							pend_byte_d = '0;
							state_d     = ST_ONE;
						end else if (first_cr_q) begin
							state_d = (count_q == '0) ? ST_END : ST_RADDR;
						end
					end else if (in_byte == tle_pkg::C_CR) begin
						state_d = ST_CR;
					end else if (in_byte == tle_pkg::C_ESC) begin
						phase_d = ESC_SECOND;
					end else if (in_byte == tle_pkg::C_BS ||
							in_byte == tle_pkg::C_DEL) begin
						// Backspace echoes only when there is something to drop.
						if (count_q != '0) begin
							count_d     = count_q - 1'b1;
							pend_kind_d = tle_pkg::K_ECHO;
							pend_byte_d = in_byte;
							state_d     = ST_ONE;
						end
					end else if (count_q < limit) begin
						// Ordinary character: store and echo it.
						ram_we      = 1'b1;
						count_d     = count_q + 1'b1;
						pend_kind_d = tle_pkg::K_ECHO;
						pend_byte_d = in_byte;
						state_d     = ST_ONE;
					end
				end
			end
			ST_ONE: begin
				if (free) begin
					push         = 1'b1;
					res.kind     = pend_kind_q;
					res.out_byte = pend_byte_q;
					res.last     = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_CR: begin
				if (free) begin
					push         = 1'b1;
					res.kind     = tle_pkg::K_ECHO;
					res.out_byte = tle_pkg::C_CR;
					state_d      = ST_LF;
				end
			end
			ST_LF: begin
				if (free) begin
					push         = 1'b1;
					res.kind     = tle_pkg::K_ECHO;
					res.out_byte = tle_pkg::C_LF;
					state_d      = (count_q == '0) ? ST_END : ST_RADDR;
				end
			end
			ST_RADDR: begin
				// Fetch the next stored character.
				ram_re  = 1'b1;
				state_d = ST_RDATA;
			end
			ST_RDATA: begin
				if (free) begin
					push         = 1'b1;
					res.kind     = tle_pkg::K_CHAR;
					res.out_byte = ram_rdata;
					idx_d        = idx_q + 1'b1;
					state_d      = (idx_d == count_q) ? ST_END : ST_RADDR;
				end
			end
			ST_END: begin
				if (free) begin
					push            = 1'b1;
					res.kind        = tle_pkg::K_END;
					res.line_length = count_q;
					res.last        = 1'b1;
					count_d         = '0;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= ESC_NONE;
			bracket_q   <= 1'b0;
			first_cr_q  <= 1'b0;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			phase_q    <= phase_d;
			bracket_q  <= bracket_d;
			first_cr_q <= first_cr_d;
			count_q    <= count_d;
			idx_q      <= idx_d;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		pend_kind_q <= pend_kind_d;
		pend_byte_q <= pend_byte_d;
		if (push) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign result       = out_q;
	assign status.idle  = (state_q == ST_IDLE);
	assign status.count = count_q;

endmodule

`default_nettype wire

// ----- hdl/terminal_line_editor.sv -----
// Terminal line editor. A printing byte is stored and echoed while the line
// is shorter than max_chars, and a backspace on a non-empty line drops the
// last character and is echoed; the block takes no new byte until that echo
// is loaded into the result register. Escape bytes that give no result leave
// the block idle. A carriage return gives two echo results, then for each
// stored character a line-store read followed by loading the result register,
// then the line-end result. The line store is a 32-byte synchronous RAM with
// no clearing pass; max_chars sits at byte address 0 of the APB port and
// resets to 31.
// Depends on tle_pkg, tle_ram and tle_seq.
`default_nettype none

module terminal_line_editor (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// Configuration port.
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [3:0]                  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	// Byte input.
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [tle_pkg::BYTE_W-1:0]  in_byte,
	// Result output.
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [tle_pkg::KIND_W-1:0]  kind,
	output logic      [tle_pkg::BYTE_W-1:0]  out_byte,
	output logic      [tle_pkg::COUNT_W-1:0] line_length,
	output logic                             last
);

	logic [tle_pkg::COUNT_W-1:0] max_chars_q;
	logic                        sel_max_chars;
	tle_pkg::tle_result_t        result;
	tle_pkg::tle_status_t        status;
	logic                        ram_we;
	logic [tle_pkg::IDX_W-1:0]   ram_waddr;
	logic [tle_pkg::BYTE_W-1:0]  ram_wdata;
	logic                        ram_re;
	logic [tle_pkg::IDX_W-1:0]   ram_raddr;
	logic [tle_pkg::BYTE_W-1:0]  ram_rdata;

	// Register decode and write.
	assign pready        = 1'b1;
	assign sel_max_chars = (paddr[3:2] == tle_pkg::REG_MAX_CHARS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chars_q <= 5'd31;
		end else if (psel && penable && pwrite && sel_max_chars) begin
			max_chars_q <= pwdata[tle_pkg::COUNT_W-1:0];
		end
	end

	// Register read.
	always_comb begin
		prdata = '0;
		if (sel_max_chars) begin
			prdata[tle_pkg::COUNT_W-1:0] = max_chars_q;
		end
	end

	// Line store.
	tle_ram #(
		.WIDTH(tle_pkg::BYTE_W),
		.DEPTH(tle_pkg::BUFFER_BYTES)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Byte decode and result sequencing.
	tle_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.max_chars (max_chars_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.status    (status)
	);

	assign kind        = result.kind;
	assign out_byte    = result.out_byte;
	assign line_length = result.line_length;
	assign last        = result.last;

	// A result that is not the last of its request means the block is busy.
	a_busy_mid_request: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> !in_ready)
		else $error("new request accepted while a request is still emitting");

	// Only a line end carries a length.
	a_length_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != tle_pkg::K_END) |-> (line_length == '0))
		else $error("line length set on a result that is not a line end");

	// The stored character count never passes the store size less one.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		int'(status.count) <= tle_pkg::CAP_CHARS)
		else $error("character count beyond the line store");

	// A line end leaves the line empty.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && kind == tle_pkg::K_END && status.idle)
		|-> (status.count == '0))
		else $error("line not cleared after line end");

endmodule

`default_nettype wire
